// File: design/led_animation_envelope_assert.svh
// Assertion macros used by the animation envelope top level.
`ifndef LED_ANIMATION_ENVELOPE_ASSERT_SVH
`define LED_ANIMATION_ENVELOPE_ASSERT_SVH
`ifndef SYNTH
`define LAE_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define LAE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define LAE_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define LAE_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: design/lae_pkg.sv
// Types, constants and helpers shared by the animation envelope pipeline.
package lae_pkg;

  localparam int DIV_STEPS = 24;
  localparam int NUM_W = 24;
  localparam int DEN_W = 17;

  // Reciprocal of ten, exact for any 24-bit dividend.
  localparam logic [23:0] TEN_RECIP = 24'hCCCCCD;
  localparam int TEN_SHIFT = 27;
  localparam logic [16:0] HUE_SPAN = 17'd1530;
  localparam logic [9:0] STROBE_MS = 10'd1000;

  typedef enum logic [2:0] {
    MODE_SOLID, MODE_FADE, MODE_BREATHE, MODE_PULSE,
    MODE_BLINK, MODE_HUE, MODE_STROBE, MODE_MODIFIER
  } mode_t;

  typedef enum logic [1:0] {REG_RISE, REG_HOLD, REG_FALL} pulse_region_t;

  typedef logic [2:0][7:0] rgb_t;

  typedef struct packed {
    mode_t          mode;
    logic [15:0]    elapsed;
    logic [15:0]    duration;
    logic [7:0]     param_one;
    logic [7:0]     param_two;
    logic [1:0]     shape;
    rgb_t           from_c;
    rgb_t           to_c;
    logic [15:0]    rise_ms;
    logic [15:0]    hold_ms;
    logic [9:0]     strobe_per;
    logic [23:0]    hue_prod;
    pulse_region_t  region;
    logic           sat;
    logic [16:0]    den2;
    logic           on;
    logic [10:0]    hue_pos;
    logic [7:0]     frac;
    logic [7:0]     mod_a;
    logic [7:0]     mod_b;
  } ctx_t;

  typedef struct packed {
    logic valid;
    ctx_t ctx;
  } pipe_t;

  typedef struct packed {
    logic             valid;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] rem;
    logic [DEN_W-1:0] den;
    ctx_t             ctx;
  } div_st_t;

  typedef struct packed {
    logic       valid;
    rgb_t       rgb;
    logic [7:0] modv;
    logic       unch;
  } res_t;

  // A zero parameter behaves as one.
  function automatic logic [7:0] nz8(input logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

endpackage

// File: design/lae_div.sv
// Pipelined restoring divider, one quotient bit per stage, with side context.
module lae_div import lae_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  pipe_t            din,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output pipe_t            dout,
  output logic [NUM_W-1:0] quo,
  output logic [DEN_W-1:0] rem
);

  localparam int LAST = DIV_STEPS - 1;

  div_st_t st [DIV_STEPS];
  div_st_t head;

  // The quotient bits shift into the low end of the dividend as it drains.
  function automatic div_st_t div_step(input div_st_t s);
    logic [DEN_W:0] trial;
    div_st_t r;
    r = s;
    trial = {s.rem, s.num[NUM_W-1]};
    if (trial >= {1'b0, s.den}) begin
      r.rem = DEN_W'(trial - {1'b0, s.den});
      r.num = {s.num[NUM_W-2:0], 1'b1};
    end else begin
      r.rem = trial[DEN_W-1:0];
      r.num = {s.num[NUM_W-2:0], 1'b0};
    end
    return r;
  endfunction

  always_comb begin
    head.valid = din.valid;
    head.num   = num;
    head.rem   = '0;
    head.den   = den;
    head.ctx   = din.ctx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_STEPS; i++) st[i].valid <= 1'b0;
    end else if (en) begin
      st[0] <= div_step(head);
      for (int i = 1; i < DIV_STEPS; i++) st[i] <= div_step(st[i-1]);
    end
  end

  assign dout.valid = st[LAST].valid;
  assign dout.ctx   = st[LAST].ctx;
  assign quo        = st[LAST].num;
  assign rem        = st[LAST].rem;

endmodule

// File: design/lae_setup.sv
// Pulse timing, hue scaling and operand selection for the remainder divider.
module lae_setup import lae_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  pipe_t            din,
  input  logic [NUM_W-1:0] q1,
  output pipe_t            dout,
  output logic [NUM_W-1:0] num2,
  output logic [DEN_W-1:0] den2
);

  pipe_t mid;
  pipe_t m_next;
  pipe_t p_next;
  logic        over;
  logic [7:0]  rise;
  logic [7:0]  fall;
  logic [7:0]  hold;
  logic [23:0] rise_prod;
  logic [23:0] hold_prod;
  logic [16:0] rh_sum;
  logic [15:0] fall_el;
  logic [15:0] fall_span;
  logic [16:0] fall_den;
  logic [47:0] hue_full;
  logic [20:0] hue_ten;
  logic [NUM_W-1:0] num_next;
  logic [DEN_W-1:0] den_next;

  // Shares that exceed the full scale are renormalized by the first divider.
  always_comb begin
    over = ({1'b0, din.ctx.param_one} + {1'b0, din.ctx.param_two}) > 9'd255;
    rise = over ? q1[7:0] : din.ctx.param_one;
    fall = over ? 8'd255 - rise : din.ctx.param_two;
    hold = 8'd255 - rise - fall;
    rise_prod = {8'b0, din.ctx.duration} * {16'b0, rise};
    hold_prod = {8'b0, din.ctx.duration} * {16'b0, hold};
    m_next = din;
    m_next.ctx.rise_ms    = rise_prod[23:8];
    m_next.ctx.hold_ms    = hold_prod[23:8];
    m_next.ctx.strobe_per = q1[9:0];
    m_next.ctx.hue_prod   = {8'b0, din.ctx.elapsed} * {16'b0, nz8(din.ctx.param_one)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid.valid <= 1'b0;
    end else if (en) begin
      mid <= m_next;
    end
  end

  always_comb begin
    rh_sum    = {1'b0, mid.ctx.rise_ms} + {1'b0, mid.ctx.hold_ms};
    fall_el   = mid.ctx.elapsed - mid.ctx.rise_ms - mid.ctx.hold_ms;
    fall_span = mid.ctx.duration - mid.ctx.rise_ms - mid.ctx.hold_ms;
    fall_den  = {1'b0, fall_span} + 17'd1;
    hue_full  = {24'b0, mid.ctx.hue_prod} * {24'b0, TEN_RECIP};
    hue_ten   = hue_full[TEN_SHIFT +: 21];
    p_next = mid;
    p_next.ctx.sat = mid.ctx.elapsed >= mid.ctx.duration;
    if (mid.ctx.elapsed < mid.ctx.rise_ms) begin
      p_next.ctx.region = REG_RISE;
    end else if ({1'b0, mid.ctx.elapsed} < rh_sum) begin
      p_next.ctx.region = REG_HOLD;
    end else begin
      p_next.ctx.region = REG_FALL;
    end
    num_next = {8'b0, mid.ctx.elapsed};
    den_next = {1'b0, mid.ctx.duration};
    unique case (mid.ctx.mode) inside
      MODE_PULSE: begin
        if (p_next.ctx.region == REG_FALL) begin
          num_next = {8'b0, fall_el};
          den_next = fall_den;
        end else begin
          den_next = {1'b0, mid.ctx.rise_ms} + 17'd1;
        end
      end
      MODE_BLINK:  den_next = {8'b0, nz8(mid.ctx.param_one), 1'b0};
      MODE_STROBE: den_next = {7'b0, mid.ctx.strobe_per};
      MODE_HUE: begin
        num_next = {3'b0, hue_ten};
        den_next = HUE_SPAN;
      end
      MODE_SOLID, MODE_FADE, MODE_BREATHE, MODE_MODIFIER: ;
      default: ;
    endcase
    p_next.ctx.den2 = den_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout <= p_next;
      num2 <= num_next;
      den2 <= den_next;
    end
  end

endmodule

// File: design/lae_shade.sv
// Blend fraction shaping, endpoint-exact lerp and final colour selection.
module lae_shade import lae_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  pipe_t      din,
  input  logic [7:0] q3,
  output res_t       res
);

  pipe_t f1;
  pipe_t f1_next;
  res_t  res_next;
  logic [7:0]  prog;
  logic [7:0]  inv;
  logic [15:0] sq;
  logic [7:0]  ease;
  logic [7:0]  prog_dn;
  logic [7:0]  bell;
  rgb_t        mixed;
  logic [7:0]  mod_mix;
  logic [2:0]  seg;
  logic [10:0] base;
  logic [7:0]  rem;

  function automatic logic [7:0] lerp8(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] f);
    logic [7:0]  diff;
    logic [15:0] prod;
    logic [7:0]  step;
    diff = (a < b) ? b - a : a - b;
    prod = {8'b0, diff} * {8'b0, f};
    step = prod[15:8];
    if (f == 8'd255) return b;
    if (a < b) return a + step;
    return a - step;
  endfunction

  always_comb begin
    prog    = din.ctx.sat ? 8'd255 : q3;
    inv     = 8'd255 - q3;
    sq      = {8'b0, inv} * {8'b0, inv};
    ease    = 8'd255 - sq[15:8];
    prog_dn = 8'd255 - prog;
    bell    = prog[7] ? {prog_dn[6:0], 1'b0} : {prog[6:0], 1'b0};
    f1_next = din;
    f1_next.ctx.mod_a = (din.ctx.shape != 2'd0) ? din.ctx.param_two : din.ctx.param_one;
    f1_next.ctx.mod_b = (din.ctx.shape != 2'd0) ? din.ctx.param_one : din.ctx.param_two;
    case (din.ctx.mode) inside
      MODE_FADE:     f1_next.ctx.frac = prog;
      MODE_BREATHE:  f1_next.ctx.frac = ease;
      MODE_MODIFIER: f1_next.ctx.frac = din.ctx.shape[1] ? bell : prog;
      MODE_PULSE: begin
        case (din.ctx.region)
          REG_RISE: f1_next.ctx.frac = q3;
          REG_FALL: f1_next.ctx.frac = 8'd255 - q3;
          default:  f1_next.ctx.frac = 8'd255;
        endcase
      end
      default: f1_next.ctx.frac = q3;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1.valid <= 1'b0;
    end else if (en) begin
      f1 <= f1_next;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mixed[i] = lerp8(f1.ctx.from_c[i], f1.ctx.to_c[i], f1.ctx.frac);
    end
    mod_mix = lerp8(f1.ctx.mod_a, f1.ctx.mod_b, f1.ctx.frac);
    if (f1.ctx.hue_pos < 11'd255) begin
      seg = 3'd0; base = 11'd0;
    end else if (f1.ctx.hue_pos < 11'd510) begin
      seg = 3'd1; base = 11'd255;
    end else if (f1.ctx.hue_pos < 11'd765) begin
      seg = 3'd2; base = 11'd510;
    end else if (f1.ctx.hue_pos < 11'd1020) begin
      seg = 3'd3; base = 11'd765;
    end else if (f1.ctx.hue_pos < 11'd1275) begin
      seg = 3'd4; base = 11'd1020;
    end else begin
      seg = 3'd5; base = 11'd1275;
    end
    rem = 8'(f1.ctx.hue_pos - base);

    res_next.valid = f1.valid;
    res_next.rgb   = '0;
    res_next.modv  = 8'd0;
    res_next.unch  = 1'b0;
    unique case (f1.ctx.mode) inside
      MODE_SOLID: res_next.rgb = f1.ctx.to_c;
      MODE_FADE, MODE_PULSE: res_next.rgb = mixed;
      MODE_BREATHE: begin
        if (f1.ctx.duration < 16'd2) res_next.unch = 1'b1;
        else res_next.rgb = mixed;
      end
      MODE_BLINK: res_next.rgb = f1.ctx.on ? f1.ctx.to_c : f1.ctx.from_c;
      MODE_STROBE: res_next.rgb = f1.ctx.on ? f1.ctx.to_c : '0;
      MODE_HUE: begin
        case (seg)
          3'd0: res_next.rgb = {8'd0, rem, 8'd255};
          3'd1: res_next.rgb = {8'd0, 8'd255, 8'd255 - rem};
          3'd2: res_next.rgb = {rem, 8'd255, 8'd0};
          3'd3: res_next.rgb = {8'd255, 8'd255 - rem, 8'd0};
          3'd4: res_next.rgb = {8'd255, 8'd0, rem};
          default: res_next.rgb = {8'd255 - rem, 8'd0, 8'd255};
        endcase
      end
      MODE_MODIFIER: begin
        res_next.modv = (f1.ctx.duration == 16'd0) ? f1.ctx.param_two : mod_mix;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (en) begin
      res <= res_next;
    end
  end

endmodule

// File: design/led_animation_envelope.sv
// Animation envelope evaluator: one layer evaluation in, one colour word out.
//
// Input channel: in_valid / in_stall with mode, timing, parameters and the
// two resolved colours. Output channel: out_valid / out_stall with the RGB
// colour, the modifier value and the unchanged flag.
// Every word passes from acceptance to out_valid through three 24-stage
// restoring dividers (share renormalization and strobe period, time
// remainder, fractional progress) with two setup stages and one operand
// stage between them, and two shading stages after the last divider.
// A new word is accepted in every cycle while the output is not stalled, so
// throughput is one word per cycle; the three divider pipelines hold most stages.
// When the receiver stalls a valid output, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is dropped or repeated.
// Reset is synchronous and clears every valid bit; the block keeps no state
// between words.
`include "led_animation_envelope_assert.svh"
module led_animation_envelope import lae_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  mode,
  input  logic [15:0] elapsed_ms,
  input  logic [15:0] duration_ms,
  input  logic [7:0]  param_one,
  input  logic [7:0]  param_two,
  input  logic [1:0]  modifier_shape,
  input  logic [7:0]  from_red,
  input  logic [7:0]  from_green,
  input  logic [7:0]  from_blue,
  input  logic [7:0]  to_red,
  input  logic [7:0]  to_green,
  input  logic [7:0]  to_blue,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  modifier_value,
  output logic        unchanged
);

  logic en;
  pipe_t d0;
  logic [NUM_W-1:0] num1;
  logic [DEN_W-1:0] den1;
  pipe_t d1_out;
  logic [NUM_W-1:0] quo1;
  logic [DEN_W-1:0] rem1;
  pipe_t s_out;
  logic [NUM_W-1:0] num2;
  logic [DEN_W-1:0] den2;
  pipe_t d2_out;
  logic [NUM_W-1:0] quo2;
  logic [DEN_W-1:0] rem2;
  pipe_t q_st;
  pipe_t q_next;
  logic [NUM_W-1:0] num3;
  logic [DEN_W-1:0] den3;
  logic [NUM_W-1:0] num3_next;
  logic [DEN_W-1:0] den3_next;
  logic [15:0] half;
  logic [15:0] r16;
  logic [15:0] fold;
  pipe_t d3_out;
  logic [NUM_W-1:0] quo3;
  logic [DEN_W-1:0] rem3;
  res_t res;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_comb begin
    d0.valid = in_valid;
    d0.ctx = '0;
    d0.ctx.mode      = mode_t'(mode);
    d0.ctx.elapsed   = elapsed_ms;
    d0.ctx.duration  = duration_ms;
    d0.ctx.param_one = param_one;
    d0.ctx.param_two = param_two;
    d0.ctx.shape     = modifier_shape;
    d0.ctx.from_c    = {from_blue, from_green, from_red};
    d0.ctx.to_c      = {to_blue, to_green, to_red};
    if (d0.ctx.mode == MODE_PULSE) begin
      num1 = {8'b0, {param_one, 8'b0} - {8'b0, param_one}};
      den1 = {8'b0, {1'b0, param_one} + {1'b0, param_two}};
    end else begin
      num1 = {14'b0, STROBE_MS};
      den1 = {9'b0, nz8(param_one)};
    end
  end

  lae_div u_div_share (
    .clk(clk), .rst(rst), .en(en), .din(d0), .num(num1), .den(den1),
    .dout(d1_out), .quo(quo1), .rem(rem1)
  );

  lae_setup u_setup (
    .clk(clk), .rst(rst), .en(en), .din(d1_out), .q1(quo1),
    .dout(s_out), .num2(num2), .den2(den2)
  );

  lae_div u_div_time (
    .clk(clk), .rst(rst), .en(en), .din(s_out), .num(num2), .den(den2),
    .dout(d2_out), .quo(quo2), .rem(rem2)
  );

  // Breathe folds the period at its midpoint; the rest scale the remainder by 256.
  always_comb begin
    r16  = rem2[15:0];
    half = {1'b0, d2_out.ctx.duration[15:1]};
    fold = (r16 <= half) ? r16 : d2_out.ctx.duration - r16;
    q_next = d2_out;
    q_next.ctx.hue_pos = rem2[10:0];
    q_next.ctx.on = 1'b0;
    if (d2_out.ctx.mode == MODE_BLINK) begin
      q_next.ctx.on = r16 < {8'b0, nz8(d2_out.ctx.param_one)};
    end else if (d2_out.ctx.mode == MODE_STROBE) begin
      q_next.ctx.on = r16 < {7'b0, d2_out.ctx.strobe_per[9:1]};
    end
    if (d2_out.ctx.mode == MODE_BREATHE) begin
      num3_next = {fold, 8'b0} - {8'b0, fold};
      den3_next = {1'b0, half};
    end else begin
      num3_next = {r16, 8'b0};
      den3_next = d2_out.ctx.den2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_st.valid <= 1'b0;
    end else if (en) begin
      q_st <= q_next;
      num3 <= num3_next;
      den3 <= den3_next;
    end
  end

  lae_div u_div_frac (
    .clk(clk), .rst(rst), .en(en), .din(q_st), .num(num3), .den(den3),
    .dout(d3_out), .quo(quo3), .rem(rem3)
  );

  lae_shade u_shade (
    .clk(clk), .rst(rst), .en(en), .din(d3_out), .q3(quo3[7:0]), .res(res)
  );

  assign out_valid      = res.valid;
  assign out_red        = res.rgb[0];
  assign out_green      = res.rgb[1];
  assign out_blue       = res.rgb[2];
  assign modifier_value = res.modv;
  assign unchanged      = res.unch;

  `LAE_ASSERT_NOW(a_unch_blank, clk, rst, out_valid && unchanged, out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0 && modifier_value == 8'd0)
  `LAE_ASSERT_NOW(a_mod_alone, clk, rst, out_valid && modifier_value != 8'd0, out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0 && !unchanged)
  `LAE_ASSERT_NOW(a_reset_flush, clk, rst, $past(rst), !out_valid)

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for the LED animation envelope evaluator.
module tb;
  import lae_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] mode = '0;
  logic [15:0] elapsed_ms = '0, duration_ms = '0;
  logic [7:0] param_one = '0, param_two = '0;
  logic [1:0] modifier_shape = '0;
  logic [7:0] from_red = '0, from_green = '0, from_blue = '0;
  logic [7:0] to_red = '0, to_green = '0, to_blue = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_red, out_green, out_blue, modifier_value;
  logic unchanged;

  typedef struct packed {
    logic [7:0] r, g, b, modv;
    logic unch;
  } colour_word_t;

  typedef struct packed {
    logic [2:0] md;
    logic [15:0] el, dur;
    logic [7:0] p1, p2;
    logic [1:0] shp;
    logic [7:0] fr, fg, fb, tr, tg, tb_;
  } layer_t;

  colour_word_t expected_words[$];
  int errors = 0;
  int words_seen = 0;
  int items_sent = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit long_hold = 1'b0;
  longint cycles = 0;

  led_animation_envelope i_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd2000000) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [7:0] blend8(logic [7:0] a, logic [7:0] b, logic [31:0] f);
    logic [31:0] d;
    if (a == b || f == 0) return a;
    if (f == 255) return b;
    if (a < b) begin
      d = ((b - a) * f) >> 8;
      return a + d[7:0];
    end
    d = ((a - b) * f) >> 8;
    return a - d[7:0];
  endfunction

  function automatic logic [31:0] progress8(logic [31:0] el, logic [31:0] dur);
    logic [31:0] p;
    if (dur == 0) return 32'd255;
    p = (el * 256) / dur;
    return (p > 255) ? 32'd255 : p;
  endfunction

  function automatic colour_word_t evaluate_layer(layer_t l);
    colour_word_t w;
    logic [31:0] el, dur, p1, p2, f, half, t, ph, inv;
    logic [31:0] rp, fp, hp, rms, hms, fe, fd, per, h, seg, rem, q, bb;
    logic [31:0] cr, cg, cb;
    logic [7:0] c[3], fc[3], tc[3];
    bit blend;
    el = {16'd0, l.el}; dur = {16'd0, l.dur};
    p1 = {24'd0, l.p1}; p2 = {24'd0, l.p2};
    fc[0] = l.fr; fc[1] = l.fg; fc[2] = l.fb;
    tc[0] = l.tr; tc[1] = l.tg; tc[2] = l.tb_;
    c[0] = 8'd0; c[1] = 8'd0; c[2] = 8'd0;
    w = '0; blend = 1'b0; f = 0;
    case (mode_t'(l.md))
      MODE_SOLID: c = tc;
      MODE_FADE: begin f = progress8(el, dur); blend = 1'b1; end
      MODE_BREATHE: begin
        half = dur / 2;
        if (half == 0) w.unch = 1'b1;
        else begin
          t = el % dur;
          if (t <= half) ph = (t * 255) / half;
          else ph = ((dur - t) * 255) / half;
          ph &= 32'hFF;
          inv = 255 - ph;
          f = 255 - ((inv * inv) >> 8);
          blend = 1'b1;
        end
      end
      MODE_PULSE: begin
        rp = p1; fp = p2;
        if (rp + fp > 255) begin
          rp = (255 * rp) / (rp + fp);
          fp = 255 - rp;
        end
        hp = (255 - rp - fp) & 32'hFF;
        rms = ((dur * rp) / 256) & 32'hFFFF;
        hms = ((dur * hp) / 256) & 32'hFFFF;
        if (el < rms) f = ((el * 256) / (rms + 1)) & 32'hFF;
        else if (el < rms + hms) f = 255;
        else begin
          fe = (el - rms - hms) & 32'hFFFF;
          fd = (dur - rms - hms) & 32'hFFFF;
          f = (255 - (((fe * 256) / (fd + 1)) & 32'hFF)) & 32'hFF;
        end
        blend = 1'b1;
      end
      MODE_BLINK: begin
        per = p1 ? p1 : 1;
        c = ((el % (per * 2)) < per) ? tc : fc;
      end
      MODE_HUE: begin
        per = p1 ? p1 : 1;
        h = ((el * per) / 10) % 1530;
        seg = h / 255; rem = h % 255;
        case (seg)
          0: begin cr = 255; cg = rem; cb = 0; end
          1: begin cr = 255 - rem; cg = 255; cb = 0; end
          2: begin cr = 0; cg = 255; cb = rem; end
          3: begin cr = 0; cg = 255 - rem; cb = 255; end
          4: begin cr = rem; cg = 0; cb = 255; end
          default: begin cr = 255; cg = 0; cb = 255 - rem; end
        endcase
        c[0] = cr[7:0]; c[1] = cg[7:0]; c[2] = cb[7:0];
      end
      MODE_STROBE: begin
        per = 1000 / (p1 ? p1 : 1);
        if ((el % per) < (per / 2)) c = tc;
      end
      default: begin
        if (dur == 0) w.modv = p2[7:0];
        else begin
          q = progress8(el, dur);
          if (l.shp[1]) begin
            bb = (q < 128) ? q * 2 : (255 - q) * 2;
            if (bb > 255) bb = 255;
            w.modv = blend8(p2[7:0], p1[7:0], bb);
          end else if (l.shp[0]) w.modv = blend8(p2[7:0], p1[7:0], q);
          else w.modv = blend8(p1[7:0], p2[7:0], q);
        end
      end
    endcase
    if (blend) for (int i = 0; i < 3; i++) c[i] = blend8(fc[i], tc[i], f);
    w.r = c[0]; w.g = c[1]; w.b = c[2];
    return w;
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    errors++;
    $display("Mismatch on word %0d: %s got %0h expected %0h", words_seen, what, got, want);
  endtask

  // Receiver: randomized stall, plus an optional long hold-off.
  int hold_left = 0;
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else if (long_hold && hold_left == 0) begin
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (hold_left > 1) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (hold_left == 1) begin
        hold_left <= 0;
        long_hold <= 1'b0;
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    colour_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        errors++;
        $display("Unexpected word with nothing pending");
      end else begin
        want = expected_words.pop_front();
        if (out_red !== want.r) report_mismatch("out_red", out_red, want.r);
        if (out_green !== want.g) report_mismatch("out_green", out_green, want.g);
        if (out_blue !== want.b) report_mismatch("out_blue", out_blue, want.b);
        if (modifier_value !== want.modv)
          report_mismatch("modifier_value", modifier_value, want.modv);
        if (unchanged !== want.unch)
          report_mismatch("unchanged", {7'd0, unchanged}, {7'd0, want.unch});
      end
      words_seen++;
    end
  end

  task automatic send_layer(layer_t l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= l.md; elapsed_ms <= l.el; duration_ms <= l.dur;
    param_one <= l.p1; param_two <= l.p2; modifier_shape <= l.shp;
    from_red <= l.fr; from_green <= l.fg; from_blue <= l.fb;
    to_red <= l.tr; to_green <= l.tg; to_blue <= l.tb_;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_words.push_back(evaluate_layer(l));
    items_sent++;
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick16();
    case ($urandom_range(5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(3));
      3: return 16'($urandom_range(300));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic layer_t random_layer();
    layer_t l;
    l = '0;
    l.md = 3'($urandom_range(7));
    l.el = pick16();
    l.dur = pick16();
    if (($urandom_range(3) == 0) && l.dur != 0) l.el = 16'($urandom_range(l.dur));
    l.p1 = ($urandom_range(4) == 0) ? 8'd0 : 8'($urandom);
    l.p2 = ($urandom_range(4) == 0) ? 8'hFF : 8'($urandom);
    l.shp = 2'($urandom_range(3));
    l.fr = 8'($urandom); l.fg = 8'($urandom); l.fb = 8'($urandom);
    l.tr = 8'($urandom); l.tg = 8'($urandom); l.tb_ = 8'($urandom);
    return l;
  endfunction

  task automatic test_directed();
    layer_t l;
    for (int m = 0; m < 8; m++) begin
      l = '0; l.md = 3'(m); l.tr = 8'hFF; l.tg = 8'h80; l.fb = 8'hFF;
      send_layer(l);
      l = '1; l.md = 3'(m); l.shp = m[1:0];
      send_layer(l);
    end
    // Breathe with duration one sets the unchanged flag; duration two does not.
    l = '0; l.md = MODE_BREATHE; l.dur = 16'd1; l.tr = 8'h55; send_layer(l);
    l.dur = 16'd2; l.el = 16'd1; send_layer(l);
    // Pulse past its duration wraps the fall progress.
    l = '1; l.md = MODE_PULSE; l.dur = 16'd100; l.el = 16'd5000; l.p1 = 8'd200;
    l.p2 = 8'd200; l.fr = 8'd0; send_layer(l);
    // Modifier with zero duration returns the identity; shape 3 acts as bell.
    l = '0; l.md = MODE_MODIFIER; l.p2 = 8'hA5; l.p1 = 8'h3C; send_layer(l);
    l.dur = 16'd256; l.el = 16'd128; l.shp = 2'd3; send_layer(l);
    l.shp = 2'd1; send_layer(l);
    l.shp = 2'd0; send_layer(l);
    l = '1; l.md = MODE_STROBE; l.p1 = 8'd0; l.el = 16'd499; send_layer(l);
    go_idle();
  endtask

  task automatic test_random_phase(int idle, int stall, int n);
    send_idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < n; i++) send_layer(random_layer());
    go_idle();
  endtask

  task automatic test_backpressure();
    long_hold <= 1'b1;
    send_idle_pct = 0;
    for (int i = 0; i < 200; i++) send_layer(random_layer());
    go_idle();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_phase(0, 0, 400);
    test_random_phase(82, 0, 350);
    test_random_phase(0, 82, 350);
    test_random_phase(36, 36, 300);
    test_backpressure();
    stall_pct = 0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d layer words across all eight modes and checked %0d results,",
             items_sent, words_seen);
    $display("under free flow, sender gaps, receiver stalls and a long hold-off.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("Verification failed");
    end
    $finish;
  end
endmodule
